FILE: rtl/core/hscf_pkg.sv
// ----------------------------------------------------------------------------
// hscf_pkg
// Shared types, constants and defaults of the hodoscope/tracker
// coincidence finder.
// ----------------------------------------------------------------------------
package hscf_pkg;

   localparam int TIME_W = 40;
   localparam int SUM_W  = 41;
   localparam int POS_W  = 16;
   localparam int ADDR_W = 32;
   localparam int CFG_W  = 17;
   localparam int CSR_IDX_W = 3;
   localparam int TRK_W  = TIME_W + 2 * POS_W;
   localparam int RES_W  = 2 * POS_W + TIME_W + SUM_W;
   localparam int QUEUE_DEPTH = 4;

   localparam int MAX_HITS_DEF    = 256;
   localparam int MAX_MATCHES_DEF = 64;

   localparam logic [ADDR_W-1:0] ADDR_FRONT_A = 32'h1000_8002;
   localparam logic [ADDR_W-1:0] ADDR_FRONT_B = 32'h1200_8002;
   localparam logic [ADDR_W-1:0] ADDR_TRK_A   = 32'h1000_8012;
   localparam logic [ADDR_W-1:0] ADDR_TRK_B   = 32'h1200_8012;
   localparam logic [ADDR_W-1:0] ADDR_BACK_A  = 32'h1000_8022;
   localparam logic [ADDR_W-1:0] ADDR_BACK_B  = 32'h1200_8022;

   localparam logic [CSR_IDX_W-1:0] CSR_HODO_START = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HODO_STOP  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STS_START  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STS_STOP   = 3'd3;

   localparam logic signed [CFG_W-1:0] HODO_START_RST = -17'sd600;
   localparam logic signed [CFG_W-1:0] HODO_STOP_RST  = 17'sd600;
   localparam logic signed [CFG_W-1:0] STS_START_RST  = -17'sd1000;
   localparam logic signed [CFG_W-1:0] STS_STOP_RST   = 17'sd1000;

   typedef enum logic [1:0] {
      CLS_NONE,
      CLS_FRONT,
      CLS_TRK,
      CLS_BACK
   } cls_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_LOAD,
      BK_INS_RD,
      BK_INS_CMP,
      BK_INS_PUT,
      BK_POST,
      BK_A_RD,
      BK_A_EV,
      BK_B_CHK,
      BK_B_EV,
      BK_S_CHK,
      BK_S_EV,
      BK_EM_START,
      BK_EM_RD,
      BK_EM_LD
   } bk_state_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] hodo_lo;
      logic signed [CFG_W-1:0] hodo_hi;
      logic signed [CFG_W-1:0] sts_lo;
      logic signed [CFG_W-1:0] sts_hi;
   } cfg_type;

   typedef struct packed {
      cls_type                  cls;
      logic                     last;
      logic [TIME_W-1:0]        t;
      logic signed [POS_W-1:0]  x;
      logic signed [POS_W-1:0]  y;
   } q_entry_type;

   typedef struct packed {
      logic                     match_valid;
      logic signed [POS_W-1:0]  match_x;
      logic signed [POS_W-1:0]  match_y;
      logic [TIME_W-1:0]        match_time;
      logic [SUM_W-1:0]         pair_time_sum;
      logic                     overflow_flag;
      logic                     result_last;
   } rsp_payload_type;

endpackage

FILE: rtl/core/hscf_req_if.sv
// ----------------------------------------------------------------------------
// hscf_req_if
// Request channel: one hit or slice-closing marker per request.
// ----------------------------------------------------------------------------
interface hscf_req_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       hit_present;
   logic [hscf_pkg::ADDR_W-1:0]                hit_address;
   logic [hscf_pkg::TIME_W-1:0]                hit_time;
   logic signed [hscf_pkg::POS_W-1:0]          hit_x;
   logic signed [hscf_pkg::POS_W-1:0]          hit_y;
   logic                                       slice_last;

   modport source (output valid, hit_present, hit_address, hit_time, hit_x, hit_y,
                   slice_last, input ready);
   modport sink   (input valid, hit_present, hit_address, hit_time, hit_x, hit_y,
                   slice_last, output ready);
endinterface

// ----------------------------------------------------------------------------
// hscf_rsp_if
// Result channel: one match per transfer; an empty slice gives one empty final result.
// ----------------------------------------------------------------------------
interface hscf_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic                                       match_valid;
   logic signed [hscf_pkg::POS_W-1:0]          match_x;
   logic signed [hscf_pkg::POS_W-1:0]          match_y;
   logic [hscf_pkg::TIME_W-1:0]                match_time;
   logic [hscf_pkg::SUM_W-1:0]                 pair_time_sum;
   logic                                       overflow_flag;
   logic                                       result_last;

   modport source (output valid, match_valid, match_x, match_y, match_time,
                   pair_time_sum, overflow_flag, result_last, input ready);
   modport sink   (input valid, match_valid, match_x, match_y, match_time,
                   pair_time_sum, overflow_flag, result_last, output ready);
endinterface

FILE: rtl/core/hscf_ram.sv
// ----------------------------------------------------------------------------
// hscf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hscf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: rtl/core/hscf_front.sv
// ----------------------------------------------------------------------------
// hscf_front
// Classify each request by address and push it to the work queue.
// ----------------------------------------------------------------------------
module hscf_front (
   hscf_req_if.sink                 req_chan,
   input  logic                     q_full,
   output logic                     q_push,
   output hscf_pkg::q_entry_type    q_entry
);

   hscf_pkg::cls_type cls;

   always_comb begin
      cls = hscf_pkg::CLS_NONE;
      if (req_chan.hit_present) begin
         if (req_chan.hit_address == hscf_pkg::ADDR_FRONT_A ||
             req_chan.hit_address == hscf_pkg::ADDR_FRONT_B) begin
            cls = hscf_pkg::CLS_FRONT;
         end else if (req_chan.hit_address == hscf_pkg::ADDR_TRK_A ||
                      req_chan.hit_address == hscf_pkg::ADDR_TRK_B) begin
            cls = hscf_pkg::CLS_TRK;
         end else if (req_chan.hit_address == hscf_pkg::ADDR_BACK_A ||
                      req_chan.hit_address == hscf_pkg::ADDR_BACK_B) begin
            cls = hscf_pkg::CLS_BACK;
         end
      end
   end

   assign req_chan.ready = !q_full;

   // drop requests that neither store a hit nor close the slice
   assign q_push = req_chan.valid && !q_full &&
                   (req_chan.slice_last || cls != hscf_pkg::CLS_NONE);

   assign q_entry.cls  = cls;
   assign q_entry.last = req_chan.slice_last;
   assign q_entry.t    = req_chan.hit_time;
   assign q_entry.x    = req_chan.hit_x;
   assign q_entry.y    = req_chan.hit_y;

endmodule

FILE: rtl/core/hscf_queue.sv
// ----------------------------------------------------------------------------
// hscf_queue
// Short FIFO between the classifying front and the sorting/matching back.
// ----------------------------------------------------------------------------
module hscf_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  hscf_pkg::q_entry_type    push_data,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output hscf_pkg::q_entry_type    head
);

   localparam int PW = $clog2(hscf_pkg::QUEUE_DEPTH);

   hscf_pkg::q_entry_type slot_ff [hscf_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   fill_ff, fill_in;

   assign full      = (fill_ff == (PW+1)'(hscf_pkg::QUEUE_DEPTH));
   assign not_empty = (fill_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/hscf_back.sv
// ----------------------------------------------------------------------------
// hscf_back
// Insert hits into time-ordered stores, scan pairs against the tracker on
// the slice end, buffer the matches and stream them out.
// ----------------------------------------------------------------------------
module hscf_back #(
   parameter int MAX_HITS    = hscf_pkg::MAX_HITS_DEF,
   parameter int MAX_MATCHES = hscf_pkg::MAX_MATCHES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  hscf_pkg::cfg_type        cfg,
   input  logic                     q_valid,
   input  hscf_pkg::q_entry_type    q_data,
   output logic                     q_pop,
   hscf_rsp_if.source               rsp_chan
);

   localparam int AW = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
   localparam int CW = $clog2(MAX_HITS + 1);
   localparam int RW = (MAX_MATCHES > 1) ? $clog2(MAX_MATCHES) : 1;
   localparam int NW = $clog2(MAX_MATCHES + 1);
   localparam int TW = hscf_pkg::TIME_W;
   localparam int SW = hscf_pkg::SUM_W;
   localparam int PW = hscf_pkg::POS_W;
   localparam int KW = hscf_pkg::TRK_W;

   hscf_pkg::bk_state_type state_ff, state_in;
   hscf_pkg::q_entry_type  ent_ff, ent_in;
   hscf_pkg::rsp_payload_type out_ff, out_in;
   logic out_vld_ff, out_vld_in;

   logic [CW-1:0] fc_ff, fc_in, bc_ff, bc_in, tc_ff, tc_in;
   logic          ovf_ff, ovf_in, trunc_ff, trunc_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] a_ff, a_in, b_ff, b_in, bs_ff, bs_in, s_ff, s_in, ss_ff, ss_in;
   logic [TW-1:0] ta_ff, ta_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [NW-1:0] n_ff, n_in, k_ff, k_in;

   // store RAM ports
   logic          f_we, b_we, t_we, r_we;
   logic [AW-1:0] f_wa, b_wa, t_wa, f_ra, b_ra, t_ra;
   logic [TW-1:0] f_wd, b_wd, f_rd, b_rd;
   logic [KW-1:0] t_wd, t_rd;
   logic [RW-1:0] r_wa, r_ra;
   logic [hscf_pkg::RES_W-1:0] r_wd, r_rd;

   hscf_ram #(.WIDTH(TW), .DEPTH(MAX_HITS)) u_front_ram (
      .clock, .wr_en(f_we), .wr_addr(f_wa), .wr_data(f_wd), .rd_addr(f_ra), .rd_data(f_rd));
   hscf_ram #(.WIDTH(TW), .DEPTH(MAX_HITS)) u_back_ram (
      .clock, .wr_en(b_we), .wr_addr(b_wa), .wr_data(b_wd), .rd_addr(b_ra), .rd_data(b_rd));
   hscf_ram #(.WIDTH(KW), .DEPTH(MAX_HITS)) u_trk_ram (
      .clock, .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd), .rd_addr(t_ra), .rd_data(t_rd));
   hscf_ram #(.WIDTH(hscf_pkg::RES_W), .DEPTH(MAX_MATCHES)) u_res_ram (
      .clock, .wr_en(r_we), .wr_addr(r_wa), .wr_data(r_wd), .rd_addr(r_ra), .rd_data(r_rd));

   // selected store during insertion
   logic [CW-1:0] cnt_sel;
   logic [KW-1:0] rec_rd, rec_ent;
   logic [CW-1:0] jm1;
   logic signed [TW+1:0] dh, hlo, hhi;
   logic signed [TW+2:0] ds2, slo2, shi2;
   logic out_free;

   always_comb begin
      case (ent_ff.cls)
         hscf_pkg::CLS_FRONT: begin cnt_sel = fc_ff; rec_rd = {f_rd, {(2*PW){1'b0}}}; end
         hscf_pkg::CLS_BACK:  begin cnt_sel = bc_ff; rec_rd = {b_rd, {(2*PW){1'b0}}}; end
         hscf_pkg::CLS_TRK:   begin cnt_sel = tc_ff; rec_rd = t_rd; end
         default:             begin cnt_sel = '0;    rec_rd = t_rd; end
      endcase
   end

   assign rec_ent = {ent_ff.t, ent_ff.x, ent_ff.y};
   assign jm1     = j_ff - 1'b1;
   assign dh      = $signed({2'b00, b_rd}) - $signed({2'b00, ta_ff});
   assign hlo     = (TW+2)'($signed(cfg.hodo_lo));
   assign hhi     = (TW+2)'($signed(cfg.hodo_hi));
   assign ds2     = $signed({2'b00, t_rd[KW-1 -: TW], 1'b0}) - $signed({2'b00, sum_ff});
   assign slo2    = {(TW+2)'($signed(cfg.sts_lo)), 1'b0};
   assign shi2    = {(TW+2)'($signed(cfg.sts_hi)), 1'b0};
   assign out_free = !out_vld_ff || rsp_chan.ready;

   always_comb begin
      state_in   = state_ff;
      ent_in     = ent_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_chan.ready;
      fc_in = fc_ff; bc_in = bc_ff; tc_in = tc_ff;
      ovf_in = ovf_ff; trunc_in = trunc_ff;
      j_in = j_ff;
      a_in = a_ff; b_in = b_ff; bs_in = bs_ff; s_in = s_ff; ss_in = ss_ff;
      ta_in = ta_ff; sum_in = sum_ff;
      n_in = n_ff; k_in = k_ff;
      q_pop = 1'b0;

      f_we = 1'b0; b_we = 1'b0; t_we = 1'b0; r_we = 1'b0;
      f_wa = j_ff[AW-1:0]; b_wa = j_ff[AW-1:0]; t_wa = j_ff[AW-1:0];
      f_wd = rec_ent[KW-1 -: TW]; b_wd = rec_ent[KW-1 -: TW]; t_wd = rec_ent;
      f_ra = jm1[AW-1:0]; b_ra = jm1[AW-1:0]; t_ra = jm1[AW-1:0];
      r_wa = n_ff[RW-1:0];
      r_wd = {t_rd[2*PW-1:PW], t_rd[PW-1:0], t_rd[KW-1 -: TW], sum_ff};
      r_ra = k_ff[RW-1:0];

      case (state_ff)
         hscf_pkg::BK_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               ent_in   = q_data;
               state_in = hscf_pkg::BK_LOAD;
            end
         end
         hscf_pkg::BK_LOAD: begin
            j_in = cnt_sel;
            if (ent_ff.cls == hscf_pkg::CLS_NONE) begin
               state_in = hscf_pkg::BK_POST;
            end else if (cnt_sel == CW'(MAX_HITS)) begin
               ovf_in   = 1'b1;
               state_in = hscf_pkg::BK_POST;
            end else if (cnt_sel == '0) begin
               state_in = hscf_pkg::BK_INS_PUT;
            end else begin
               state_in = hscf_pkg::BK_INS_RD;
            end
         end
         hscf_pkg::BK_INS_RD: begin
            state_in = hscf_pkg::BK_INS_CMP;
         end
         hscf_pkg::BK_INS_CMP: begin
            // shift the larger entry up one place, else drop the new hit in
            if (rec_rd[KW-1 -: TW] > ent_ff.t) begin
               f_wd = rec_rd[KW-1 -: TW]; b_wd = rec_rd[KW-1 -: TW]; t_wd = rec_rd;
               j_in = jm1;
               state_in = (jm1 == '0) ? hscf_pkg::BK_INS_PUT : hscf_pkg::BK_INS_RD;
            end else begin
               state_in = hscf_pkg::BK_INS_PUT;
            end
            f_we = (ent_ff.cls == hscf_pkg::CLS_FRONT) &&
                   (rec_rd[KW-1 -: TW] > ent_ff.t);
            b_we = (ent_ff.cls == hscf_pkg::CLS_BACK) &&
                   (rec_rd[KW-1 -: TW] > ent_ff.t);
            t_we = (ent_ff.cls == hscf_pkg::CLS_TRK) &&
                   (rec_rd[KW-1 -: TW] > ent_ff.t);
         end
         hscf_pkg::BK_INS_PUT: begin
            f_we = (ent_ff.cls == hscf_pkg::CLS_FRONT);
            b_we = (ent_ff.cls == hscf_pkg::CLS_BACK);
            t_we = (ent_ff.cls == hscf_pkg::CLS_TRK);
            if (f_we) fc_in = fc_ff + 1'b1;
            if (b_we) bc_in = bc_ff + 1'b1;
            if (t_we) tc_in = tc_ff + 1'b1;
            state_in = hscf_pkg::BK_POST;
         end
         hscf_pkg::BK_POST: begin
            if (ent_ff.last) begin
               a_in = '0; bs_in = '0; ss_in = '0; n_in = '0; trunc_in = 1'b0;
               state_in = hscf_pkg::BK_A_RD;
            end else begin
               state_in = hscf_pkg::BK_IDLE;
            end
         end
         hscf_pkg::BK_A_RD: begin
            f_ra = a_ff[AW-1:0];
            state_in = (a_ff >= fc_ff) ? hscf_pkg::BK_EM_START : hscf_pkg::BK_A_EV;
         end
         hscf_pkg::BK_A_EV: begin
            ta_in    = f_rd;
            b_in     = bs_ff;
            state_in = hscf_pkg::BK_B_CHK;
         end
         hscf_pkg::BK_B_CHK: begin
            b_ra = b_ff[AW-1:0];
            if (b_ff >= bc_ff) begin
               a_in     = a_ff + 1'b1;
               state_in = hscf_pkg::BK_A_RD;
            end else begin
               state_in = hscf_pkg::BK_B_EV;
            end
         end
         hscf_pkg::BK_B_EV: begin
            if (dh < hlo) begin
               bs_in    = b_ff;
               b_in     = b_ff + 1'b1;
               state_in = hscf_pkg::BK_B_CHK;
            end else if (hhi < dh) begin
               a_in     = a_ff + 1'b1;
               state_in = hscf_pkg::BK_A_RD;
            end else begin
               sum_in   = SW'(ta_ff) + SW'(b_rd);
               s_in     = ss_ff;
               state_in = hscf_pkg::BK_S_CHK;
            end
         end
         hscf_pkg::BK_S_CHK: begin
            t_ra = s_ff[AW-1:0];
            if (s_ff >= tc_ff) begin
               b_in     = b_ff + 1'b1;
               state_in = hscf_pkg::BK_B_CHK;
            end else begin
               state_in = hscf_pkg::BK_S_EV;
            end
         end
         hscf_pkg::BK_S_EV: begin
            if (ds2 < slo2) begin
               ss_in    = s_ff;
               s_in     = s_ff + 1'b1;
               state_in = hscf_pkg::BK_S_CHK;
            end else if (shi2 < ds2) begin
               b_in     = b_ff + 1'b1;
               state_in = hscf_pkg::BK_B_CHK;
            end else if (n_ff == NW'(MAX_MATCHES)) begin
               trunc_in = 1'b1;
               state_in = hscf_pkg::BK_EM_START;
            end else begin
               r_we     = 1'b1;
               n_in     = n_ff + 1'b1;
               s_in     = s_ff + 1'b1;
               state_in = hscf_pkg::BK_S_CHK;
            end
         end
         hscf_pkg::BK_EM_START: begin
            k_in = '0;
            if (n_ff != '0) begin
               state_in = hscf_pkg::BK_EM_RD;
            end else if (out_free) begin
               out_in            = '0;
               out_in.overflow_flag = ovf_ff;
               out_in.result_last   = 1'b1;
               out_vld_in        = 1'b1;
               fc_in = '0; bc_in = '0; tc_in = '0; ovf_in = 1'b0;
               state_in          = hscf_pkg::BK_IDLE;
            end
         end
         hscf_pkg::BK_EM_RD: begin
            state_in = hscf_pkg::BK_EM_LD;
         end
         hscf_pkg::BK_EM_LD: begin
            if (out_free) begin
               out_in.match_valid   = 1'b1;
               {out_in.match_x, out_in.match_y, out_in.match_time,
                out_in.pair_time_sum} = r_rd;
               out_in.overflow_flag = ovf_ff || trunc_ff;
               out_in.result_last   = (k_ff + 1'b1 == n_ff);
               out_vld_in           = 1'b1;
               k_in                 = k_ff + 1'b1;
               if (k_ff + 1'b1 == n_ff) begin
                  fc_in = '0; bc_in = '0; tc_in = '0; ovf_in = 1'b0;
                  state_in = hscf_pkg::BK_IDLE;
               end else begin
                  state_in = hscf_pkg::BK_EM_RD;
               end
            end
         end
         default: begin
            state_in = hscf_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= hscf_pkg::BK_IDLE;
         out_vld_ff <= 1'b0;
         fc_ff      <= '0;
         bc_ff      <= '0;
         tc_ff      <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         fc_ff      <= fc_in;
         bc_ff      <= bc_in;
         tc_ff      <= tc_in;
         ovf_ff     <= ovf_in;
      end
   end

   always_ff @(posedge clock) begin
      ent_ff   <= ent_in;
      out_ff   <= out_in;
      trunc_ff <= trunc_in;
      j_ff     <= j_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      bs_ff    <= bs_in;
      s_ff     <= s_in;
      ss_ff    <= ss_in;
      ta_ff    <= ta_in;
      sum_ff   <= sum_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
   end

   assign rsp_chan.valid         = out_vld_ff;
   assign rsp_chan.match_valid   = out_ff.match_valid;
   assign rsp_chan.match_x       = out_ff.match_x;
   assign rsp_chan.match_y       = out_ff.match_y;
   assign rsp_chan.match_time    = out_ff.match_time;
   assign rsp_chan.pair_time_sum = out_ff.pair_time_sum;
   assign rsp_chan.overflow_flag = out_ff.overflow_flag;
   assign rsp_chan.result_last   = out_ff.result_last;

endmodule

FILE: rtl/core/hodoscope_sts_coincidence_finder_top.sv
// ----------------------------------------------------------------------------
// hodoscope_sts_coincidence_finder_top
// Time-window coincidence finder between front/back hodoscope and tracker.
// ----------------------------------------------------------------------------
// Insertion: each later-timed entry of the store is shifted up one place
//   before a stored hit is written; an ignored or dropped hit is not stored.
// Slice end: the scan visits front, back and tracker entries, then streams
//   out the results; an empty slice gives one result.
// Throughput: the four-entry queue accepts a request per cycle until full.
// Reset: synchronous, active high; clears counts, flags, queue and window
//   registers to their defaults. Store contents are not cleared.
module hodoscope_sts_coincidence_finder_top #(
   parameter int MAX_HITS    = hscf_pkg::MAX_HITS_DEF,
   parameter int MAX_MATCHES = hscf_pkg::MAX_MATCHES_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   hscf_req_if.sink                         req_chan,
   hscf_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [hscf_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hscf_pkg::CFG_W-1:0]       csr_wdata
);

   // window registers
   hscf_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            hscf_pkg::CSR_HODO_START: cfg_in.hodo_lo = csr_wdata;
            hscf_pkg::CSR_HODO_STOP:  cfg_in.hodo_hi = csr_wdata;
            hscf_pkg::CSR_STS_START:  cfg_in.sts_lo  = csr_wdata;
            hscf_pkg::CSR_STS_STOP:   cfg_in.sts_hi  = csr_wdata;
            default:                  cfg_in = cfg_ff;  // drop unknown index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hodo_lo <= hscf_pkg::HODO_START_RST;
         cfg_ff.hodo_hi <= hscf_pkg::HODO_STOP_RST;
         cfg_ff.sts_lo  <= hscf_pkg::STS_START_RST;
         cfg_ff.sts_hi  <= hscf_pkg::STS_STOP_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: classify and enqueue
   logic                  q_push, q_pop, q_full, q_not_empty;
   hscf_pkg::q_entry_type q_in_entry, q_head;

   hscf_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (q_in_entry)
   );

   hscf_queue u_queue (
      .clock,
      .reset,
      .push      (q_push),
      .push_data (q_in_entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (q_head)
   );

   // back: sorted insertion, pair scan and result streaming
   hscf_back #(
      .MAX_HITS    (MAX_HITS),
      .MAX_MATCHES (MAX_MATCHES)
   ) u_back (
      .clock,
      .reset,
      .cfg      (cfg_ff),
      .q_valid  (q_not_empty),
      .q_data   (q_head),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

FILE: rtl/core/hscf_port_chk.sv
// ----------------------------------------------------------------------------
// hscf_port_chk
// Port-level checks on the result channel of the coincidence finder.
// ----------------------------------------------------------------------------
module hscf_port_chk (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          match_valid,
   input logic [hscf_pkg::TIME_W-1:0]   match_time,
   input logic [hscf_pkg::SUM_W-1:0]    pair_time_sum,
   input logic                          result_last
);

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before taken");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown after reset");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !match_valid |-> result_last)
      else $error("empty result not final");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !match_valid |-> match_time == '0 && pair_time_sum == '0)
      else $error("empty result carries data");

endmodule

bind hodoscope_sts_coincidence_finder_top hscf_port_chk u_port_chk (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .match_valid   (rsp_chan.match_valid),
   .match_time    (rsp_chan.match_time),
   .pair_time_sum (rsp_chan.pair_time_sum),
   .result_last   (rsp_chan.result_last)
);
